// ===== rtl/tgad_pkg.sv =====
// Package for the TGA byte-stream decoder: parser phase type and the
// colour helper functions. It depends on nothing else.
`default_nettype none

package tgad_pkg;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_SKIP_ID = 3'd1,
        PH_MAP     = 3'd2,
        PH_PACKET  = 3'd3,
        PH_ELEMENT = 3'd4,
        PH_IDLE    = 3'd5
    } t_phase;

    localparam int unsigned HEADER_LEN = 18;

    // Header byte positions that carry fields.
    localparam logic [4:0] HB_ID_LEN    = 5'd0;
    localparam logic [4:0] HB_MAP_TYPE  = 5'd1;
    localparam logic [4:0] HB_IMG_TYPE  = 5'd2;
    localparam logic [4:0] HB_MAP_LEN_L = 5'd5;
    localparam logic [4:0] HB_MAP_LEN_H = 5'd6;
    localparam logic [4:0] HB_MAP_BITS  = 5'd7;
    localparam logic [4:0] HB_WIDTH_L   = 5'd12;
    localparam logic [4:0] HB_WIDTH_H   = 5'd13;
    localparam logic [4:0] HB_HEIGHT_L  = 5'd14;
    localparam logic [4:0] HB_HEIGHT_H  = 5'd15;
    localparam logic [4:0] HB_PIX_BITS  = 5'd16;

    // Supported image types.
    localparam logic [7:0] TYPE_MAPPED     = 8'd1;
    localparam logic [7:0] TYPE_TRUE       = 8'd2;
    localparam logic [7:0] TYPE_RLE_MAPPED = 8'd9;
    localparam logic [7:0] TYPE_RLE_TRUE   = 8'd10;

    // Widens a 5-bit channel to 8 bits by repeating its top bits.
    function automatic logic [7:0] widen5(input logic [4:0] c);
        widen5 = {c, c[4:2]};
    endfunction

    // Bytes per element: depth/8 clamped to 1..4.
    function automatic logic [2:0] elem_bytes(input logic [7:0] bits);
        logic [4:0] n;
        n = bits[7:3];
        if (n == 5'd0) begin
            elem_bytes = 3'd1;
        end else if (n > 5'd4) begin
            elem_bytes = 3'd4;
        end else begin
            elem_bytes = n[2:0];
        end
    endfunction

    // Unpacks a 2, 3 or 4 byte element to ARGB8888; other sizes give zero.
    function automatic logic [31:0] unpack_color(input logic [31:0] v,
                                                 input logic [2:0] n);
        logic [4:0] r;
        logic [4:0] g;
        logic [4:0] b;
        r = v[14:10];
        g = v[9:5];
        b = v[4:0];
        case (n)
            3'd2: begin
                unpack_color = {(v[15] ? 8'hFF : 8'h00), widen5(r), widen5(g), widen5(b)};
            end
            3'd3: begin
                unpack_color = {8'hFF, v[23:0]};
            end
            3'd4: begin
                unpack_color = v;
            end
            default: begin
                unpack_color = 32'd0;
            end
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tgad_in_if.sv =====
// Input channel of the TGA decoder: one file byte per beat.
// Stands alone; no package needed.
`default_nettype none

interface tgad_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       first_byte;

    modport source (output valid, output file_byte, output first_byte, input ready);
    modport sink   (input valid, input file_byte, input first_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/tgad_out_if.sv =====
// Output channel of the TGA decoder: one pixel run per beat.
// Stands alone; no package needed.
`default_nettype none

interface tgad_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] color;
    logic [7:0]  repeat_res;
    logic        last;
    logic        unsupported;

    modport source (output valid, output color, output repeat_res, output last,
                    output unsupported, input ready);
    modport sink   (input valid, input color, input repeat_res, input last,
                    input unsupported, output ready);
endinterface

`default_nettype wire

// ===== rtl/tga_image_stream_decoder.sv =====
// Top level of the TGA byte-stream decoder: header parser, colour map load
// and RLE/raw pixel decode. Depends on tgad_pkg, tgad_in_if, tgad_out_if, tgad_palette.
//
//   Channel | Dir | Beat carries
//   i_in    | in  | file_byte, first_byte (restart marker)
//   o_out   | out | color, repeat_res, last, unsupported
//
// One byte is taken per cycle; the parser state advances in the cycle the beat
// is accepted, and any result is registered into the output register at the same
// clock edge. The colour map read happens in the accepting cycle, its registered
// data is selected at the output. A stalled output holds its beat; a new byte is
// still taken when the output is empty or being drained. Reset clears the parser;
// the colour map holds no reset and is only read at entries loaded from the file.
`default_nettype none

module tga_image_stream_decoder #(
    parameter int unsigned PALETTE_ENTRIES = 256
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tgad_in_if.sink   i_in,
    tgad_out_if.source o_out
);
    import tgad_pkg::*;

    localparam int unsigned AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    // Parser state.
    t_phase      r_phase,  n_phase;
    logic [4:0]  r_hidx,   n_hidx;
    logic [7:0]  r_id_len, n_id_len;
    logic [7:0]  r_map_present, n_map_present;
    logic [7:0]  r_type,   n_type;
    logic [15:0] r_map_len, n_map_len;
    logic [7:0]  r_map_bits, n_map_bits;
    logic [7:0]  r_pix_bits, n_pix_bits;
    logic [17:0] r_count,  n_count;
    logic [23:0] r_cbytes, n_cbytes;
    logic [1:0]  r_bic,    n_bic;
    logic        r_is_run, n_is_run;
    logic [7:0]  r_pkt_rem, n_pkt_rem;
    logic [31:0] r_pix_rem, n_pix_rem;
    logic [15:0] r_map_idx, n_map_idx;

    // Output register.
    logic        r_o_valid;
    logic        r_use_pal;
    logic [31:0] r_direct;
    logic [7:0]  r_rep;
    logic        r_last;
    logic        r_unsup;

    logic        acc;
    logic [7:0]  b;
    logic        first;

    // State seen by this byte: cleared when a new file starts.
    t_phase      c_phase;
    logic [4:0]  c_hidx;
    logic [1:0]  c_bic;
    logic [23:0] c_cbytes;

    // Element assembly.
    logic [2:0]  elem_n;
    logic [31:0] full;
    logic        complete;

    // Result of this byte.
    logic        emit;
    logic        emit_pal;
    logic [31:0] emit_direct;
    logic [7:0]  emit_rep;
    logic        emit_last;
    logic        emit_unsup;
    logic [31:0] pix_after;
    logic [7:0]  pkt_after;

    logic        pal_we;
    logic [31:0] pal_wdata;
    logic [31:0] pal_rdata;

    assign acc   = i_in.valid && i_in.ready;
    assign b     = i_in.file_byte;
    assign first = i_in.first_byte;
    assign i_in.ready = !r_o_valid || o_out.ready;

    // Effective state and element byte assembly.
    always_comb begin
        c_phase  = first ? PH_HEADER : r_phase;
        c_hidx   = first ? 5'd0 : r_hidx;
        c_bic    = first ? 2'd0 : r_bic;
        c_cbytes = first ? 24'd0 : r_cbytes;
        elem_n   = (c_phase == PH_MAP) ? elem_bytes(r_map_bits) : elem_bytes(r_pix_bits);
        full     = {8'd0, c_cbytes} | ({24'd0, b} << {c_bic, 3'b000});
        complete = ({1'b0, c_bic} + 3'd1) >= elem_n;
    end

    // Result of the byte, and pixel/packet counters after it.
    always_comb begin
        emit        = 1'b0;
        emit_pal    = 1'b0;
        emit_direct = 32'd0;
        emit_rep    = 8'd1;
        emit_last   = 1'b0;
        emit_unsup  = 1'b0;
        pix_after   = r_pix_rem;
        pkt_after   = r_pkt_rem;
        case (c_phase)
            PH_HEADER: begin
                if (c_hidx == HB_IMG_TYPE && b != TYPE_MAPPED && b != TYPE_TRUE
                        && b != TYPE_RLE_MAPPED && b != TYPE_RLE_TRUE) begin
                    emit       = 1'b1;
                    emit_last  = 1'b1;
                    emit_unsup = 1'b1;
                end
            end
            PH_ELEMENT: begin
                if (complete) begin
                    emit = 1'b1;
                    if (r_type == TYPE_MAPPED || r_type == TYPE_RLE_MAPPED) begin
                        emit_pal = (full < {16'd0, r_map_len})
                                   && (full < 32'(PALETTE_ENTRIES));
                    end else begin
                        emit_direct = unpack_color(full, elem_n);
                    end
                    if (r_type[3] && r_is_run) begin
                        emit_rep = r_pkt_rem;
                    end
                    if ({24'd0, emit_rep} > r_pix_rem) begin
                        emit_rep = r_pix_rem[7:0];
                    end
                    pix_after = r_pix_rem - {24'd0, emit_rep};
                    pkt_after = r_is_run ? 8'd0 : r_pkt_rem - 8'd1;
                    emit_last = (pix_after == 32'd0);
                end
            end
            default: begin
            end
        endcase
    end

    // Next parser state.
    always_comb begin
        logic [31:0] cnt;
        cnt = 32'd0;
        if (first) begin
            n_phase = PH_HEADER;     n_hidx = 5'd0;     n_id_len = 8'd0;
            n_map_present = 8'd0;    n_type = 8'd0;     n_map_len = 16'd0;
            n_map_bits = 8'd0;       n_pix_bits = 8'd0; n_count = 18'd0;
            n_cbytes = 24'd0;        n_bic = 2'd0;      n_is_run = 1'b0;
            n_pkt_rem = 8'd0;        n_pix_rem = 32'd0; n_map_idx = 16'd0;
        end else begin
            n_phase = r_phase;       n_hidx = r_hidx;   n_id_len = r_id_len;
            n_map_present = r_map_present; n_type = r_type; n_map_len = r_map_len;
            n_map_bits = r_map_bits; n_pix_bits = r_pix_bits; n_count = r_count;
            n_cbytes = r_cbytes;     n_bic = r_bic;     n_is_run = r_is_run;
            n_pkt_rem = r_pkt_rem;   n_pix_rem = r_pix_rem; n_map_idx = r_map_idx;
        end
        case (c_phase)
            PH_HEADER: begin
                case (c_hidx)
                    HB_ID_LEN:    n_id_len = b;
                    HB_MAP_TYPE:  n_map_present = b;
                    HB_IMG_TYPE:  n_type = b;
                    HB_MAP_LEN_L: n_map_len = {8'd0, b};
                    HB_MAP_LEN_H: n_map_len = {b, n_map_len[7:0]};
                    HB_MAP_BITS:  n_map_bits = b;
                    HB_WIDTH_L:   n_pix_rem = {24'd0, b};
                    HB_WIDTH_H:   n_pix_rem = {16'd0, b, n_pix_rem[7:0]};
                    HB_HEIGHT_L:  n_count = {10'd0, b};
                    HB_HEIGHT_H:  n_pix_rem = 32'(n_pix_rem[15:0]) * 32'({b, n_count[7:0]});
                    HB_PIX_BITS:  n_pix_bits = b;
                    default: begin
                    end
                endcase
                n_hidx = c_hidx + 5'd1;
                if (emit_unsup) begin
                    n_phase = PH_IDLE;
                end else if (32'(n_hidx) >= 32'(HEADER_LEN)) begin
                    n_count = {10'd0, n_id_len};
                    if (n_id_len != 8'd0) begin
                        n_phase = PH_SKIP_ID;
                    end else begin
                        n_phase = PH_MAP;
                        n_map_idx = 16'd0;
                        n_bic = 2'd0;
                        n_cbytes = 24'd0;
                        n_count = {2'd0, n_map_len} * {15'd0, elem_bytes(n_map_bits)};
                    end
                end
            end
            PH_SKIP_ID: begin
                n_count = r_count - 18'd1;
                if (n_count == 18'd0) begin
                    n_phase = PH_MAP;
                    n_map_idx = 16'd0;
                    n_bic = 2'd0;
                    n_cbytes = 24'd0;
                    n_count = {2'd0, r_map_len} * {15'd0, elem_bytes(r_map_bits)};
                end
            end
            PH_MAP: begin
                if (complete) begin
                    n_bic = 2'd0;
                    n_cbytes = 24'd0;
                    n_map_idx = r_map_idx + 16'd1;
                end else begin
                    n_bic = c_bic + 2'd1;
                    n_cbytes = full[23:0];
                end
                n_count = r_count - 18'd1;
            end
            PH_PACKET: begin
                cnt = {25'd0, b[6:0]} + 32'd1;
                if (cnt > r_pix_rem) begin
                    cnt = r_pix_rem;
                end
                n_is_run = b[7];
                n_pkt_rem = cnt[7:0];
                n_bic = 2'd0;
                n_cbytes = 24'd0;
                n_phase = PH_ELEMENT;
            end
            PH_ELEMENT: begin
                if (complete) begin
                    n_bic = 2'd0;
                    n_cbytes = 24'd0;
                    n_pix_rem = pix_after;
                    if (r_type[3]) begin
                        n_pkt_rem = pkt_after;
                        if (pkt_after == 8'd0) begin
                            n_phase = PH_PACKET;
                        end
                    end
                    if (pix_after == 32'd0) begin
                        n_phase = PH_IDLE;
                    end
                end else begin
                    n_bic = c_bic + 2'd1;
                    n_cbytes = full[23:0];
                end
            end
            default: begin
            end
        endcase
        // Entry to pixel decode, or to idle for an empty image, once the map count has drained to zero.
        if (n_phase == PH_MAP && n_count == 18'd0 && c_phase != PH_IDLE
                && c_phase != PH_PACKET && c_phase != PH_ELEMENT) begin
            n_bic = 2'd0;
            n_cbytes = 24'd0;
            if (n_pix_rem == 32'd0) begin
                n_phase = PH_IDLE;
            end else begin
                n_phase = n_type[3] ? PH_PACKET : PH_ELEMENT;
            end
        end
    end

    // Colour map write in the map phase.
    assign pal_we    = acc && c_phase == PH_MAP && complete
                       && (32'(r_map_idx) < 32'(PALETTE_ENTRIES));
    assign pal_wdata = unpack_color(full, elem_n);

    tgad_palette #(
        .ENTRIES (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (r_map_idx[AW-1:0]),
        .i_wdata (pal_wdata),
        .i_re    (acc && emit_pal),
        .i_raddr (full[AW-1:0]),
        .o_rdata (pal_rdata)
    );

    // Parser registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;    r_hidx <= 5'd0;     r_id_len <= 8'd0;
            r_map_present <= 8'd0;   r_type <= 8'd0;     r_map_len <= 16'd0;
            r_map_bits <= 8'd0;      r_pix_bits <= 8'd0; r_count <= 18'd0;
            r_cbytes <= 24'd0;       r_bic <= 2'd0;      r_is_run <= 1'b0;
            r_pkt_rem <= 8'd0;       r_pix_rem <= 32'd0; r_map_idx <= 16'd0;
        end else if (acc) begin
            r_phase <= n_phase;      r_hidx <= n_hidx;   r_id_len <= n_id_len;
            r_map_present <= n_map_present; r_type <= n_type; r_map_len <= n_map_len;
            r_map_bits <= n_map_bits; r_pix_bits <= n_pix_bits; r_count <= n_count;
            r_cbytes <= n_cbytes;    r_bic <= n_bic;     r_is_run <= n_is_run;
            r_pkt_rem <= n_pkt_rem;  r_pix_rem <= n_pix_rem; r_map_idx <= n_map_idx;
        end
    end

    // Output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_o_valid <= acc && emit;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (acc && emit) begin
            r_use_pal <= emit_pal;
            r_direct  <= emit_direct;
            r_rep     <= emit_rep;
            r_last    <= emit_last;
            r_unsup   <= emit_unsup;
        end
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.color       = r_use_pal ? pal_rdata : r_direct;
    assign o_out.repeat_res  = r_rep;
    assign o_out.last        = r_last;
    assign o_out.unsupported = r_unsup;
endmodule

`default_nettype wire

// ===== rtl/tgad_palette.sv =====
// Colour map store of the TGA decoder: one write port, one read port with
// registered read data. Stands alone; no package needed.
`default_nettype none

module tgad_palette #(
    parameter int unsigned ENTRIES = 256
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] i_waddr,
    input  wire logic [31:0]                              i_wdata,
    input  wire logic                                     i_re,
    input  wire logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] i_raddr,
    output logic [31:0]                                   o_rdata
);
    logic [31:0] r_mem [ENTRIES];
    logic [31:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data is held until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

// ===== tb/tga_image_stream_decoder_tb.sv =====
// Self-checking testbench for the TGA byte-stream decoder: builds TGA files byte
// by byte, predicts each pixel run and checks every output beat against it.
// Depends on tgad_pkg, tgad_in_if, tgad_out_if and tga_image_stream_decoder.
`default_nettype none

module tga_image_stream_decoder_tb;
    import tgad_pkg::*;

    localparam int unsigned MAP_DEPTH  = 256;
    localparam int unsigned IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [31:0] color;
        logic [7:0]  repeat_res;
        logic        last;
        logic        unsupported;
    } t_run;

    logic i_clk;
    logic i_rst_n;

    tgad_in_if  in_ch ();
    tgad_out_if out_ch ();

    tga_image_stream_decoder #(.PALETTE_ENTRIES(MAP_DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Expected pixel runs, oldest first, and the bytes of the file being built.
    t_run       runs_due[$];
    logic [7:0] file_q[$];
    int         fail_count;
    int         bytes_sent;
    int         burst_left;
    bit         gaps_on;
    int unsigned idle_cycles;
    int unsigned cyc;

    // Decoder state as predicted.
    t_phase      ph;
    int unsigned hdr_pos;
    logic [7:0]  id_len;
    logic [7:0]  img_type;
    int unsigned map_len;
    logic [7:0]  map_bits;
    logic [7:0]  pix_bits;
    logic [7:0]  height_lo;
    int unsigned byte_count;
    logic [31:0] pal[MAP_DEPTH];
    logic [23:0] elem_acc;
    int unsigned elem_pos;
    logic        run_pkt;
    int unsigned pkt_left;
    logic [31:0] pix_left;
    int unsigned entry_no;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned px_bytes(input logic [7:0] bits);
        int unsigned n;
        n = bits >> 3;
        if (n < 1) n = 1;
        if (n > 4) n = 4;
        return n;
    endfunction

    function automatic logic [7:0] stretch5(input logic [4:0] c);
        return {c, c[4:2]};
    endfunction

    function automatic logic [31:0] argb_of(input logic [31:0] v, input int unsigned n);
        case (n)
            2: begin
                return {(v[15] ? 8'hFF : 8'h00), stretch5(v[14:10]), stretch5(v[9:5]),
                        stretch5(v[4:0])};
            end
            3: return {8'hFF, v[23:0]};
            4: return v;
            default: return 32'd0;
        endcase
    endfunction

    task automatic clear_parser();
        ph = PH_HEADER;
        hdr_pos = 0;
        id_len = '0;
        img_type = '0;
        map_len = 0;
        map_bits = '0;
        pix_bits = '0;
        height_lo = '0;
        byte_count = 0;
        elem_acc = '0;
        elem_pos = 0;
        run_pkt = 1'b0;
        pkt_left = 0;
        pix_left = '0;
        entry_no = 0;
    endtask

    task automatic start_pixels();
        elem_pos = 0;
        elem_acc = '0;
        if (pix_left == 0) ph = PH_IDLE;
        else ph = img_type[3] ? PH_PACKET : PH_ELEMENT;
    endtask

    task automatic start_map();
        entry_no = 0;
        elem_pos = 0;
        elem_acc = '0;
        byte_count = map_len * px_bytes(map_bits);
        if (byte_count > 0) ph = PH_MAP;
        else start_pixels();
    endtask

    // Gathers one byte of an n-byte element; done is set with the whole element.
    task automatic gather(input logic [7:0] b, input int unsigned n,
                          output bit done, output logic [31:0] v);
        logic [31:0] full;
        full = {8'h00, elem_acc} | (32'(b) << (8 * elem_pos));
        done = 1'b0;
        v = full;
        if (elem_pos + 1 >= n) begin
            done = 1'b1;
            elem_pos = 0;
            elem_acc = '0;
        end else begin
            elem_acc = full[23:0];
            elem_pos = elem_pos + 1;
        end
    endtask

    // Advances the predicted decoder by one accepted byte.
    task automatic decode_byte(input logic [7:0] b, input logic first);
        bit          done;
        logic [31:0] v;
        logic [31:0] col;
        logic [31:0] rep;
        int unsigned n;
        if (first) clear_parser();
        case (ph)
            PH_HEADER: begin
                case (hdr_pos)
                    0: id_len = b;
                    2: begin
                        img_type = b;
                        if (b != TYPE_MAPPED && b != TYPE_TRUE && b != TYPE_RLE_MAPPED &&
                            b != TYPE_RLE_TRUE) begin
                            ph = PH_IDLE;
                            runs_due.push_back('{32'd0, 8'd1, 1'b1, 1'b1});
                            return;
                        end
                    end
                    5: map_len = 32'(b);
                    6: map_len = map_len | (32'(b) << 8);
                    7: map_bits = b;
                    12: pix_left = 32'(b);
                    13: pix_left = pix_left | (32'(b) << 8);
                    14: height_lo = b;
                    15: pix_left = 32'(pix_left[15:0]) * 32'({b, height_lo});
                    16: pix_bits = b;
                    default: ;
                endcase
                hdr_pos++;
                if (hdr_pos >= HEADER_LEN) begin
                    byte_count = 32'(id_len);
                    if (id_len > 0) ph = PH_SKIP_ID;
                    else start_map();
                end
            end
            PH_SKIP_ID: begin
                byte_count--;
                if (byte_count == 0) start_map();
            end
            PH_MAP: begin
                n = px_bytes(map_bits);
                gather(b, n, done, v);
                if (done) begin
                    if (entry_no < MAP_DEPTH) pal[entry_no] = argb_of(v, n);
                    entry_no = (entry_no + 1) & 16'hFFFF;
                end
                byte_count--;
                if (byte_count == 0) start_pixels();
            end
            PH_PACKET: begin
                pkt_left = 32'(b[6:0]) + 1;
                if (pkt_left > pix_left) pkt_left = pix_left;
                run_pkt = b[7];
                elem_pos = 0;
                elem_acc = '0;
                ph = PH_ELEMENT;
            end
            PH_ELEMENT: begin
                n = px_bytes(pix_bits);
                gather(b, n, done, v);
                if (done) begin
                    if (img_type == TYPE_MAPPED || img_type == TYPE_RLE_MAPPED)
                        col = (v < map_len && v < MAP_DEPTH) ? pal[v[7:0]] : 32'd0;
                    else
                        col = argb_of(v, n);
                    rep = (img_type[3] && run_pkt) ? pkt_left : 1;
                    if (rep > pix_left) rep = pix_left;
                    pix_left = pix_left - rep;
                    if (img_type[3]) begin
                        pkt_left = run_pkt ? 0 : pkt_left - 1;
                        if (pkt_left == 0) ph = PH_PACKET;
                    end
                    if (pix_left == 0) ph = PH_IDLE;
                    runs_due.push_back('{col, rep[7:0], pix_left == 0, 1'b0});
                end
            end
            default: ;
        endcase
    endtask

    // Sends one byte in bursts with random gaps; valid stays high inside a burst.
    task automatic send_byte(input logic [7:0] b, input logic first);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if (gaps_on) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
        in_ch.valid      <= 1'b1;
        in_ch.file_byte  <= b;
        in_ch.first_byte <= first;
        do @(posedge i_clk); while (!in_ch.ready);
        decode_byte(b, first);
        bytes_sent++;
        burst_left--;
    endtask

    // Pushes one pixel element; mapped indices mostly land near the loaded map.
    task automatic add_element(input int unsigned n, input bit mapped, input int unsigned ml);
        int unsigned idx;
        if (mapped && $urandom_range(0, 3) != 0) begin
            idx = $urandom_range(0, ml + 1);
            for (int i = 0; i < n; i++) file_q.push_back(8'(idx >> (8 * i)));
        end else begin
            for (int i = 0; i < n; i++) file_q.push_back(8'($urandom));
        end
    endtask

    // Builds a whole file: header, ID, colour map and pixel data.
    task automatic build_file(input logic [7:0] typ, input logic [7:0] idl,
                              input int unsigned ml, input logic [7:0] mbits,
                              input logic [15:0] w, input logic [15:0] h,
                              input logic [7:0] pbits);
        int unsigned n;
        int unsigned left;
        int unsigned cnt;
        logic [7:0]  pkt;
        bit          mapped;
        file_q.delete();
        file_q.push_back(idl);
        file_q.push_back(8'($urandom));
        file_q.push_back(typ);
        file_q.push_back(8'($urandom));
        file_q.push_back(8'($urandom));
        file_q.push_back(ml[7:0]);
        file_q.push_back(ml[15:8]);
        file_q.push_back(mbits);
        repeat (4) file_q.push_back(8'($urandom));
        file_q.push_back(w[7:0]);
        file_q.push_back(w[15:8]);
        file_q.push_back(h[7:0]);
        file_q.push_back(h[15:8]);
        file_q.push_back(pbits);
        file_q.push_back(8'($urandom));
        if (typ == TYPE_MAPPED || typ == TYPE_TRUE || typ == TYPE_RLE_MAPPED ||
            typ == TYPE_RLE_TRUE) begin
            repeat (idl) file_q.push_back(8'($urandom));
            repeat (ml * px_bytes(mbits)) file_q.push_back(8'($urandom));
            n = px_bytes(pbits);
            mapped = (typ == TYPE_MAPPED || typ == TYPE_RLE_MAPPED);
            left = 32'(w) * 32'(h);
            if (typ[3]) begin
                while (left > 0) begin
                    pkt = 8'($urandom);
                    if ($urandom_range(0, 2) == 0) pkt[6:0] = 7'($urandom_range(0, 3));
                    cnt = 32'(pkt[6:0]) + 1;
                    if (cnt > left) cnt = left;
                    file_q.push_back(pkt);
                    if (pkt[7]) add_element(n, mapped, ml);
                    else repeat (cnt) add_element(n, mapped, ml);
                    left -= cnt;
                end
            end else begin
                repeat (left) add_element(n, mapped, ml);
            end
        end
        repeat ($urandom_range(0, 3)) file_q.push_back(8'($urandom));
    endtask

    // Sends the built file, cut short after keep bytes.
    task automatic send_file(input int unsigned keep);
        for (int i = 0; i < file_q.size() && i < keep; i++)
            send_byte(file_q[i], i == 0);
    endtask

    function automatic logic [7:0] pick_depth();
        case ($urandom_range(0, 7))
            0: return 8'd8;
            1: return 8'd15;
            2, 3: return 8'd16;
            4, 5: return 8'd24;
            6: return 8'd32;
            default: return 8'($urandom);
        endcase
    endfunction

    // Unsupported types give one error beat, and trailing bytes are ignored.
    task automatic test_unsupported();
        build_file(8'd0, 8'd0, 0, 8'd16, 16'd2, 16'd2, 8'd24);
        send_file(100);
        build_file(8'd255, 8'd3, 4, 8'd24, 16'd1, 16'd1, 8'd24);
        send_file(100);
        build_file(8'd3, 8'd0, 0, 8'd0, 16'd1, 16'd1, 8'd8);
        send_file(100);
    endtask

    // True-colour raw images at every depth, an ID field, and empty raw and RLE images.
    task automatic test_true_color();
        build_file(TYPE_TRUE, 8'd0, 0, 8'd0, 16'd2, 16'd1, 8'd16);
        send_file(1000);
        build_file(TYPE_TRUE, 8'd5, 0, 8'd0, 16'd1, 16'd2, 8'd24);
        send_file(1000);
        build_file(TYPE_TRUE, 8'd0, 0, 8'd0, 16'd2, 16'd1, 8'd32);
        send_file(1000);
        build_file(TYPE_TRUE, 8'd0, 0, 8'd0, 16'd2, 16'd1, 8'd255);
        send_file(1000);
        build_file(TYPE_TRUE, 8'd0, 0, 8'd0, 16'd2, 16'd1, 8'd0);
        send_file(1000);
        build_file(TYPE_TRUE, 8'd0, 0, 8'd0, 16'hFFFF, 16'd0, 8'd24);
        send_file(1000);
        build_file(TYPE_RLE_TRUE, 8'd0, 0, 8'd0, 16'd0, 16'hFFFF, 8'd24);
        send_file(1000);
    endtask

    // Colour-mapped images, including a map longer than the store.
    task automatic test_color_map();
        build_file(TYPE_MAPPED, 8'd0, 4, 8'd16, 16'd3, 16'd2, 8'd8);
        send_file(1000);
        build_file(TYPE_MAPPED, 8'd1, 3, 8'd32, 16'd2, 16'd2, 8'd16);
        send_file(1000);
        build_file(TYPE_RLE_MAPPED, 8'd0, 300, 8'd8, 16'd4, 16'd2, 8'd8);
        send_file(2000);
    endtask

    // Run-length images with clipped runs and a large run-length image.
    task automatic test_rle();
        build_file(TYPE_RLE_TRUE, 8'd0, 0, 8'd0, 16'd3, 16'd3, 8'd16);
        send_file(1000);
        build_file(TYPE_RLE_TRUE, 8'd0, 2, 8'd24, 16'h0101, 16'd1, 8'd32);
        send_file(5000);
    endtask

    // Mostly well-formed random files, some truncated, with stray bytes between.
    task automatic test_random();
        logic [7:0]  typ;
        int unsigned keep;
        while (bytes_sent < 1350) begin
            gaps_on = ($urandom_range(0, 4) != 0);
            case ($urandom_range(0, 7))
                0: typ = 8'($urandom);
                1, 2: typ = TYPE_MAPPED;
                3: typ = TYPE_TRUE;
                4, 5: typ = TYPE_RLE_MAPPED;
                default: typ = TYPE_RLE_TRUE;
            endcase
            build_file(typ, ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2)),
                       $urandom_range(0, 12), pick_depth(),
                       16'($urandom_range(0, 6)), 16'($urandom_range(0, 5)), pick_depth());
            keep = ($urandom_range(0, 9) == 0) ? $urandom_range(1, file_q.size()) : 1 << 30;
            send_file(keep);
            if ($urandom_range(0, 15) == 0)
                repeat ($urandom_range(1, 5)) send_byte(8'($urandom), 1'b0);
        end
    endtask

    // Receiver stall pattern and result checking.
    always @(posedge i_clk) begin
        t_run want;
        cyc <= cyc + 1;
        case (cyc[9:7])
            0, 1: out_ch.ready <= 1'b1;
            2, 3: out_ch.ready <= 1'($urandom_range(0, 1));
            4: out_ch.ready <= (cyc[4:0] > 5'd28);
            default: out_ch.ready <= ($urandom_range(0, 3) != 0);
        endcase
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (runs_due.size() == 0) begin
                $error("unexpected beat: color %h repeat %0d", out_ch.color, out_ch.repeat_res);
                fail_count++;
            end else begin
                want = runs_due.pop_front();
                if (out_ch.color !== want.color) begin
                    $error("color: expected %h, got %h", want.color, out_ch.color);
                    fail_count++;
                end
                if (out_ch.repeat_res !== want.repeat_res) begin
                    $error("repeat_res: expected %0d, got %0d", want.repeat_res,
                           out_ch.repeat_res);
                    fail_count++;
                end
                if (out_ch.last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, out_ch.last);
                    fail_count++;
                end
                if (out_ch.unsupported !== want.unsupported) begin
                    $error("unsupported: expected %b, got %b", want.unsupported,
                           out_ch.unsupported);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no beat on either channel.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > IDLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Main sequence.
    initial begin
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.file_byte  = '0;
        in_ch.first_byte = 1'b0;
        out_ch.ready     = 1'b0;
        fail_count  = 0;
        bytes_sent  = 0;
        burst_left  = 0;
        gaps_on     = 1'b1;
        idle_cycles = 0;
        cyc         = 0;
        clear_parser();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_unsupported();
        test_true_color();
        test_color_map();
        test_rle();
        test_random();

        in_ch.valid <= 1'b0;
        while (runs_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
